### hw/rtl/lfr_pkg.sv
// Shared types, constants and helpers for the letter frequency ranker.
`default_nettype none

package lfr_pkg;

    // Alphabet and counter geometry
    localparam int NUM_LETTERS = 26;
    localparam int IDX_W       = 5;
    localparam int COUNT_W     = 32;
    localparam int OUT_W       = 32;
    localparam int DATA_W      = 8;

    // ASCII landmarks
    localparam logic [DATA_W-1:0] ASCII_UPPER_A = 8'd65;
    localparam logic [DATA_W-1:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [DATA_W-1:0] ASCII_LOWER_A = 8'd97;
    localparam logic [DATA_W-1:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [DATA_W-1:0] ASCII_CASE    = 8'd32;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [IDX_W-1:0]   idx_t;

    localparam count_t COUNT_MAX   = '1;
    localparam idx_t   LAST_IDX    = idx_t'(NUM_LETTERS - 1);

    // One entry of the ranking chain: letter and its count
    typedef struct packed {
        idx_t   id;
        count_t cnt;
    } rank_entry_t;

    // Control broadcast to the counting chain
    typedef struct packed {
        logic count_en;
        idx_t letter_idx;
        logic shift;
    } count_ctl_t;

    // Control broadcast to the ranking chain
    typedef struct packed {
        logic load;
        logic sort;
        logic phase;
        logic shift;
    } rank_ctl_t;

    // Low 32 bits of a counter, zero-extended when the counter is narrower
    function automatic logic [OUT_W-1:0] out32(input count_t v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[OUT_W-1:0];
    endfunction

    // Increment that sticks at the maximum
    function automatic count_t sat_inc(input count_t v);
        return (v == COUNT_MAX) ? v : v + count_t'(1);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lfr_count_cell.sv
// Counting cell: one letter counter that also shifts toward the chain head.
`default_nettype none

module lfr_count_cell
    import lfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire idx_t       idx,
    input  wire count_ctl_t ctl,
    input  wire count_t     right_cnt,
    output count_t          cnt
);

    count_t cnt_reg;
    count_t cnt_next;

    // Shift during report, otherwise bump on a matching letter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.shift)
        begin
            cnt_next = right_cnt;
        end
        else if (ctl.count_en && (ctl.letter_idx == idx))
        begin
            cnt_next = sat_inc(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign cnt = cnt_reg;

endmodule

`default_nettype wire

### hw/rtl/lfr_rank_cell.sv
// Ranking cell: one slot of an odd-even transposition sort that also shifts out.
`default_nettype none

module lfr_rank_cell
    import lfr_pkg::*;
(
    input  wire logic        clk,
    input  wire idx_t        idx,
    input  wire rank_ctl_t   ctl,
    input  wire count_t      load_cnt,
    input  wire rank_entry_t left_entry,
    input  wire rank_entry_t right_entry,
    output rank_entry_t      entry
);

    rank_entry_t entry_reg;
    rank_entry_t entry_next;
    logic        partner_right;
    logic        has_left;
    logic        has_right;

    assign partner_right = (idx[0] == ctl.phase);
    assign has_left      = (idx != '0);
    assign has_right     = (idx != LAST_IDX);

    // Load in letter order, swap strictly larger counts forward, shift on report
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next.id  = idx;
            entry_next.cnt = load_cnt;
        end
        else if (ctl.sort)
        begin
            if (partner_right && has_right)
            begin
                if (right_entry.cnt > entry_reg.cnt)
                begin
                    entry_next = right_entry;
                end
            end
            else if (!partner_right && has_left)
            begin
                if (entry_reg.cnt > left_entry.cnt)
                begin
                    entry_next = left_entry;
                end
            end
        end
        else if (ctl.shift)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

### hw/rtl/letter_frequency_ranker_core.sv
// Top level: byte intake, letter counting chain, ranking chain and report output.
`default_nettype none

// Counts one byte per cycle while data items arrive (s_axis_tready stays high).
// An item with s_axis_tlast set ends the data set: the input then stalls while
// the ranking chain runs 26 odd-even transposition steps and the 26 report
// rows leave at up to one per cycle while m_axis_tready is high. Ties in count
// keep alphabetical order. Counters saturate and clear once the last row is
// taken.

module letter_frequency_ranker_core
    import lfr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,  // [7:0] byte_value
    input  wire logic         s_axis_tlast,  // end_of_file
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [4:0] position, [36:5] letter_count, [41:37] ranked_letter,
    // [73:42] ranked_count, [105:74] total_letters, [137:106] total_bytes,
    // [143:138] zero
    output logic [143:0]      m_axis_tdata,
    output logic              m_axis_tlast   // last_result
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SORT   = 2'd1;
    localparam logic [1:0] ST_REPORT = 2'd2;

    logic [1:0]   state_reg;
    logic [1:0]   state_next;
    idx_t         step_reg;
    idx_t         step_next;
    count_t       byte_total_reg;
    count_t       byte_total_next;
    count_t       letter_total_reg;
    count_t       letter_total_next;

    logic         in_acc;
    logic         out_acc;
    logic         data_acc;
    logic [7:0]   upper;
    logic         is_letter;
    idx_t         letter_idx;
    logic         last_row;

    count_ctl_t   count_ctl;
    rank_ctl_t    rank_ctl;
    count_t       cnt_q  [NUM_LETTERS];
    rank_entry_t  rank_q [NUM_LETTERS];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_REPORT);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign data_acc      = in_acc && !s_axis_tlast;
    assign last_row      = (step_reg == LAST_IDX);

    // Fold lower case onto upper case and find the letter slot
    always_comb
    begin
        upper = s_axis_tdata;
        if ((s_axis_tdata >= ASCII_LOWER_A) && (s_axis_tdata <= ASCII_LOWER_Z))
        begin
            upper = s_axis_tdata - ASCII_CASE;
        end
    end

    assign is_letter  = (upper >= ASCII_UPPER_A) && (upper <= ASCII_UPPER_Z);
    assign letter_idx = idx_t'(upper - ASCII_UPPER_A);

    // Broadcast control to both chains
    always_comb
    begin
        count_ctl.count_en   = data_acc && is_letter;
        count_ctl.letter_idx = letter_idx;
        count_ctl.shift      = out_acc;
        rank_ctl.load        = in_acc && s_axis_tlast;
        rank_ctl.sort        = (state_reg == ST_SORT);
        rank_ctl.phase       = step_reg[0];
        rank_ctl.shift       = out_acc;
    end

    // Build the two chains of cells
    for (genvar k = 0; k < NUM_LETTERS; k++)
    begin : g_cell
        count_t      right_cnt;
        rank_entry_t left_entry;
        rank_entry_t right_entry;

        if (k == NUM_LETTERS - 1)
        begin : g_tail
            assign right_cnt   = '0;
            assign right_entry = '0;
        end
        else
        begin : g_mid
            assign right_cnt   = cnt_q[k+1];
            assign right_entry = rank_q[k+1];
        end

        if (k == 0)
        begin : g_head
            assign left_entry = '0;
        end
        else
        begin : g_body
            assign left_entry = rank_q[k-1];
        end

        lfr_count_cell u_count (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (idx_t'(k)),
            .ctl       (count_ctl),
            .right_cnt (right_cnt),
            .cnt       (cnt_q[k])
        );

        lfr_rank_cell u_rank (
            .clk         (clk),
            .idx         (idx_t'(k)),
            .ctl         (rank_ctl),
            .load_cnt    (cnt_q[k]),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (rank_q[k])
        );
    end

    // Sequence counting, sorting and reporting; keep the totals
    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        byte_total_next   = byte_total_reg;
        letter_total_next = letter_total_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (data_acc)
                begin
                    byte_total_next = sat_inc(byte_total_reg);
                    if (is_letter)
                    begin
                        letter_total_next = sat_inc(letter_total_reg);
                    end
                end
                else if (in_acc)
                begin
                    state_next = ST_SORT;
                    step_next  = '0;
                end
            end
            ST_SORT:
            begin
                if (last_row)
                begin
                    state_next = ST_REPORT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + idx_t'(1);
                end
            end
            ST_REPORT:
            begin
                if (out_acc)
                begin
                    if (last_row)
                    begin
                        state_next        = ST_IDLE;
                        step_next         = '0;
                        byte_total_next   = '0;
                        letter_total_next = '0;
                    end
                    else
                    begin
                        step_next = step_reg + idx_t'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            byte_total_reg   <= '0;
            letter_total_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            byte_total_reg   <= byte_total_next;
            letter_total_reg <= letter_total_next;
        end
    end

    // Present the chain heads as the current report row
    assign m_axis_tdata  = {6'd0,
                            out32(byte_total_reg),
                            out32(letter_total_reg),
                            out32(rank_q[0].cnt),
                            rank_q[0].id,
                            out32(cnt_q[0]),
                            step_reg};
    assign m_axis_tlast  = last_row;

    // Input and output sides are never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and report active together");

    // End of file starts the sort from step zero
    a_eof_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tlast) |=> (state_reg == ST_SORT && step_reg == '0))
        else $error("end of file did not start the sort");

    // Taking the final row clears the totals and the head letter counter
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && m_axis_tlast) |=>
            (state_reg == ST_IDLE && byte_total_reg == '0 &&
             letter_total_reg == '0 && cnt_q[0] == '0))
        else $error("counters not cleared after report");

    // Ranking head never holds less than its neighbor while reporting
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT) |-> (rank_q[0].cnt >= rank_q[1].cnt))
        else $error("ranking chain out of order");

    // Letters never outnumber bytes
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        letter_total_reg <= byte_total_reg)
        else $error("letter total exceeds byte total");

endmodule

`default_nettype wire
